@@ rtl/mtrd_pkg.sv @@
// shared constants, types and helpers for the ranged twister draw block
package mtrd_pkg;

   localparam int STATE_WORDS = 624;
   localparam int IDX_W = $clog2(STATE_WORDS + 1);
   localparam int ADDR_W = $clog2(STATE_WORDS);
   localparam int TW_MID = 397;

   localparam logic [31:0] TW_MATRIX = 32'h9908_B0DF;
   localparam logic [31:0] SEED_MULT = 32'd1812433253;
   localparam logic [31:0] DEFAULT_SEED = 32'd5489;
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
   localparam logic [7:0] BYTE_MASK = 8'hFF;
   localparam int FOLD_BYTES = 8;

   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_RESEED = 1'b1;

   typedef enum logic [3:0] {
      ST_SEED_INIT,
      ST_SEED_MUL,
      ST_SEED_WR,
      ST_IDLE,
      ST_TW_START,
      ST_TW_LOAD,
      ST_TW_RUN,
      ST_RD,
      ST_TEMPER,
      ST_SCALE,
      ST_FOLD_GO,
      ST_FOLD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic clear;
   } fold_ctrl_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // address wrap for values below twice the table size
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W:0] a);
      logic [ADDR_W:0] r;
      r = (a >= (ADDR_W+1)'(STATE_WORDS)) ? a - (ADDR_W+1)'(STATE_WORDS) : a;
      return r[ADDR_W-1:0];
   endfunction

endpackage

@@ rtl/mtrd_req_if.sv @@
// request and response channel interfaces
interface mtrd_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] seed_value;
   logic [32:0] range_max;
   modport source(output valid, cmd, seed_value, range_max, input ready);
   modport sink(input valid, cmd, seed_value, range_max, output ready);
endinterface

interface mtrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] draw_value;
   logic [31:0] check_value;
   modport source(output valid, draw_value, check_value, input ready);
   modport sink(input valid, draw_value, check_value, output ready);
endinterface

@@ rtl/mt19937_range_draw_checksum.sv @@
// ranged mt19937 draw with running fnv-1a checksum
// draw: rd, temper, scale and fold_go, then fold_wait until the checksum has folded the draw;
//   done then registers the response and returns to idle; a spent table is first twisted
// reseed: seed_init, then seed_mul and seed_wr for each word (one multiplier), then done
// reset seeds with 5489; no request taken meanwhile
// one request at a time; a new one is taken while the last response waits
module mt19937_range_draw_checksum
   import mtrd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   mtrd_req_if.sink   req_if,
   mtrd_rsp_if.source rsp_if
);
   state_type state_ff, state_in;

   logic [31:0] mem [STATE_WORDS];
   logic [31:0] rda_ff, rdb_ff;
   logic [ADDR_W-1:0] ra, rb, wa;
   logic [31:0] wd;
   logic we;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] w_ff, w_in;
   logic [32:0] bound_ff, bound_in;
   logic [31:0] draw_ff, draw_in;
   logic        from_cmd_ff, from_cmd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_draw_ff, rsp_draw_in;
   logic [31:0] rsp_check_ff, rsp_check_in;

   fold_ctrl_type fold_ctrl;
   logic fold_busy;
   logic [31:0] checksum;
   logic [31:0] y, v;
   logic [63:0] mult;

   mtrd_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (fold_ctrl),
      .value    (draw_ff),
      .busy     (fold_busy),
      .checksum (checksum)
   );

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rda_ff <= mem[ra];
      rdb_ff <= mem[rb];
   end

   always_comb begin
      y = {cur_ff[31], rda_ff[30:0]};
      v = rdb_ff ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
      mult = w_ff * bound_ff[31:0];
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      seed_in = seed_ff;
      prev_in = prev_ff;
      prod_in = prod_ff;
      cur_in = cur_ff;
      w_in = w_ff;
      bound_in = bound_ff;
      draw_in = draw_ff;
      from_cmd_in = from_cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_draw_in = rsp_draw_ff;
      rsp_check_in = rsp_check_ff;
      ra = '0;
      rb = '0;
      wa = cnt_ff;
      wd = '0;
      we = 1'b0;
      fold_ctrl = '0;
      req_if.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_SEED_INIT: begin
            we = 1'b1;
            wa = '0;
            wd = seed_ff;
            prev_in = seed_ff;
            cnt_in = ADDR_W'(1);
            idx_in = IDX_W'(STATE_WORDS);
            fold_ctrl.clear = 1'b1;
            state_in = ST_SEED_MUL;
         end
         ST_SEED_MUL: begin
            prod_in = 32'(SEED_MULT * (prev_ff ^ (prev_ff >> 30)));
            state_in = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            we = 1'b1;
            wa = cnt_ff;
            wd = prod_ff + 32'(cnt_ff);
            prev_in = wd;
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(STATE_WORDS - 1)) begin
               if (from_cmd_ff) begin
                  draw_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_SEED_MUL;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               from_cmd_in = 1'b1;
               if (req_if.cmd == CMD_RESEED) begin
                  seed_in = req_if.seed_value;
                  state_in = ST_SEED_INIT;
               end else begin
                  bound_in = req_if.range_max;
                  state_in = (idx_ff >= IDX_W'(STATE_WORDS)) ? ST_TW_START : ST_RD;
               end
            end
         end
         ST_TW_START: begin
            ra = '0;
            state_in = ST_TW_LOAD;
         end
         ST_TW_LOAD: begin
            cur_in = rda_ff;
            ra = ADDR_W'(1);
            rb = ADDR_W'(TW_MID);
            cnt_in = '0;
            state_in = ST_TW_RUN;
         end
         ST_TW_RUN: begin
            // reads for the next word never hit the entry written this cycle
            we = 1'b1;
            wa = cnt_ff;
            wd = v;
            cur_in = rda_ff;
            ra = wrap_addr((ADDR_W+1)'(cnt_ff) + (ADDR_W+1)'(2));
            rb = wrap_addr((ADDR_W+1)'(cnt_ff) + (ADDR_W+1)'(TW_MID + 1));
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(STATE_WORDS - 1)) begin
               idx_in = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            ra = idx_ff[ADDR_W-1:0];
            state_in = ST_TEMPER;
         end
         ST_TEMPER: begin
            w_in = temper(rda_ff);
            idx_in = idx_ff + IDX_W'(1);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            draw_in = bound_ff[32] ? w_ff : mult[63:32];
            state_in = ST_FOLD_GO;
         end
         ST_FOLD_GO: begin
            fold_ctrl.start = 1'b1;
            state_in = ST_FOLD_WAIT;
         end
         ST_FOLD_WAIT: begin
            if (!fold_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_draw_in = draw_ff;
               rsp_check_in = checksum;
               from_cmd_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEED_INIT;
         seed_ff <= DEFAULT_SEED;
         idx_ff <= IDX_W'(STATE_WORDS);
         cnt_ff <= '0;
         from_cmd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff <= seed_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         from_cmd_ff <= from_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_ff <= prev_in;
      prod_ff <= prod_in;
      cur_ff <= cur_in;
      w_ff <= w_in;
      bound_ff <= bound_in;
      draw_ff <= draw_in;
      rsp_draw_ff <= rsp_draw_in;
      rsp_check_ff <= rsp_check_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.draw_value = rsp_draw_ff;
   assign rsp_if.check_value = rsp_check_ff;

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      we |-> (wa < ADDR_W'(STATE_WORDS)))
      else $error("table write beyond last entry");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(STATE_WORDS))
      else $error("draw index past table size");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff != ST_IDLE))
      else $error("request taken but no work started");

   a_draw_reads_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (idx_ff < IDX_W'(STATE_WORDS)))
      else $error("draw read without twist");
endmodule

@@ rtl/mtrd_fold.sv @@
// fnv-1a checksum folding one byte per cycle
module mtrd_fold
   import mtrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fold_ctrl_type ctrl,
   input  logic [31:0]   value,
   output logic          busy,
   output logic [31:0]   checksum
);
   logic [31:0] sum_ff, sum_in;
   logic [31:0] val_ff, val_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;

   always_comb begin
      sum_in = sum_ff;
      val_in = val_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.clear) begin
         sum_in = FNV_BASIS;
      end else if (ctrl.start) begin
         val_in = value;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // upper four bytes of the zero-extended value come in as zeros
         sum_in = 32'((sum_ff ^ {24'd0, val_ff[7:0] & BYTE_MASK}) * FNV_PRIME);
         val_in = val_ff >> 8;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(FOLD_BYTES - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= FNV_BASIS;
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
      val_ff <= val_in;
   end

   assign busy = busy_ff;
   assign checksum = sum_ff;
endmodule
